@@ rtl/restoring_unsigned_divider_unit_defines.svh @@
// Assertion helpers used by the checker file.
// Every check samples on clk and is disabled while rst_n is low.
`ifndef RESTORING_UNSIGNED_DIVIDER_UNIT_DEFINES_SVH
`define RESTORING_UNSIGNED_DIVIDER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RUDU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RUDU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rudu_pkg.sv @@
package rudu_pkg;

    // Default operand width
    localparam int unsigned DEFAULT_WIDTH = 16;

endpackage

@@ rtl/rudu_cell.sv @@
// One restoring step: shift in the next dividend bit, trial subtract, keep or restore.
module rudu_cell #(
    parameter int unsigned WIDTH = rudu_pkg::DEFAULT_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [WIDTH-1:0] up_acc,
    input  logic [WIDTH-1:0] up_quo,
    input  logic [WIDTH-1:0] up_num,
    input  logic [WIDTH-1:0] up_den,
    output logic             down_valid,
    input  logic             down_ready,
    output logic [WIDTH-1:0] down_acc,
    output logic [WIDTH-1:0] down_quo,
    output logic [WIDTH-1:0] down_num,
    output logic [WIDTH-1:0] down_den
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] num_reg;
    logic [WIDTH-1:0] num_next;
    logic [WIDTH-1:0] den_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;
    logic             load;

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    // Partial remainder is WIDTH+1 bits; the old top bit becomes bit WIDTH.
    assign shifted = {up_acc, up_num[WIDTH-1]};
    assign diff    = shifted - {1'b0, up_den};
    assign fits    = !diff[WIDTH];

    always_comb
    begin
        acc_next   = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        quo_next   = {up_quo[WIDTH-2:0], fits};
        num_next   = {up_num[WIDTH-2:0], 1'b0};
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= acc_next;
            quo_reg <= quo_next;
            num_reg <= num_next;
            den_reg <= up_den;
        end
    end

    assign down_valid = valid_reg;
    assign down_acc   = acc_reg;
    assign down_quo   = quo_reg;
    assign down_num   = num_reg;
    assign down_den   = den_reg;

endmodule

@@ rtl/restoring_unsigned_divider_unit.sv @@
// Each accepted request word passes through WIDTH registered cells (one cell per bit) to its response word.
// Throughput: one division per cycle; a new word enters every cycle while the chain moves.
// Each cell stalls only when it holds a word and the next cell cannot take it, so bubbles close up
// and the chain keeps taking words while a finished result waits at the output.
// Reset: rst_n (async, active low) clears every cell's valid flag; operand registers are not reset.
module restoring_unsigned_divider_unit #(
    parameter int unsigned WIDTH = rudu_pkg::DEFAULT_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    // request channel
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    // response channel
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    // Link k feeds cell k; link WIDTH is the output of the last cell.
    logic             link_valid [WIDTH+1];
    logic             link_ready [WIDTH+1];
    logic [WIDTH-1:0] link_acc   [WIDTH+1];
    logic [WIDTH-1:0] link_quo   [WIDTH+1];
    logic [WIDTH-1:0] link_num   [WIDTH+1];
    logic [WIDTH-1:0] link_den   [WIDTH+1];

    // Head of the chain: partial remainder and quotient start at zero.
    assign link_valid[0] = req_valid;
    assign link_acc[0]   = '0;
    assign link_quo[0]   = '0;
    assign link_num[0]   = dividend;
    assign link_den[0]   = divisor;
    assign req_stall     = !link_ready[0];

    // Cell k resolves quotient bit WIDTH-1-k; the dividend shifts left so the next
    // bit is always at the top of the word handed on.
    for (genvar k = 0; k < WIDTH; k++)
    begin : g_cell
        rudu_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[k]),
            .up_ready   (link_ready[k]),
            .up_acc     (link_acc[k]),
            .up_quo     (link_quo[k]),
            .up_num     (link_num[k]),
            .up_den     (link_den[k]),
            .down_valid (link_valid[k+1]),
            .down_ready (link_ready[k+1]),
            .down_acc   (link_acc[k+1]),
            .down_quo   (link_quo[k+1]),
            .down_num   (link_num[k+1]),
            .down_den   (link_den[k+1])
        );
    end

    // Tail: the last cell's registers are the output register.
    // A zero divisor never fails the trial subtract: quotient all ones, remainder = dividend.
    assign link_ready[WIDTH] = !rsp_stall;
    assign rsp_valid         = link_valid[WIDTH];
    assign quotient          = link_quo[WIDTH];
    assign remainder         = link_acc[WIDTH];

endmodule

@@ rtl/rudu_checker.sv @@
`include "restoring_unsigned_divider_unit_defines.svh"

module rudu_checker #(
    parameter int unsigned WIDTH = rudu_pkg::DEFAULT_WIDTH
) (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input logic [WIDTH-1:0] quotient,
    input logic [WIDTH-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(WIDTH + 2);

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             req_take;
    logic             rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    always_comb
    begin
        occ_next = occ_reg;
        if (req_take && !rsp_take)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (rsp_take && !req_take)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `RUDU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
        rsp_valid && $stable(quotient) && $stable(remainder),
        "stalled response word changed")

    `RUDU_ASSERT_NOW(a_flow_through, !rsp_stall, !req_stall,
        "request stalled while the response side is free")

    `RUDU_ASSERT_NOW(a_no_phantom, rsp_valid, occ_reg != '0,
        "response word without an outstanding request")

    `RUDU_ASSERT_NOW(a_capacity, 1'b1, occ_reg <= CNT_W'(WIDTH),
        "more words in flight than cells")

endmodule

bind restoring_unsigned_divider_unit rudu_checker #(
    .WIDTH (WIDTH)
) u_rudu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .quotient  (quotient),
    .remainder (remainder)
);
